FILE: design/smrf_pkg.sv
`timescale 1ns / 1ps

package smrf_pkg;

  typedef logic [23:0] pix_t;

  localparam pix_t WHITE = 24'hFF_FFFF;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_REGION_ROWS  = 2'd2,
    CFG_REGION_COLS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic valid;
    logic write;
    logic emit;
    logic last;
    logic top_c;
    logic bot_c;
    logic left_c;
    logic right_c;
    logic region;
    logic use_capt;
    pix_t px;
  } item_t;

  typedef struct packed {
    logic valid;
    logic replace;
    logic last;
    col_t l;
    col_t c;
    col_t r;
  } win_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] md;
    logic [7:0] hi;
  } tri_t;

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic tri_t sort3(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
    tri_t res;
    logic [7:0] lo1;
    logic [7:0] hi1;
    logic [7:0] t;
    lo1 = min2(a, b);
    hi1 = max2(a, b);
    t = min2(hi1, c);
    res.hi = max2(hi1, c);
    res.lo = min2(lo1, t);
    res.md = max2(lo1, t);
    return res;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t clamp_col(input col_t cin, input logic top_c, input logic bot_c);
    col_t res;
    res = cin;
    if (top_c) begin
      res.top = cin.mid;
    end
    if (bot_c) begin
      res.bot = cin.mid;
    end
    return res;
  endfunction

  function automatic logic [7:0] chan(input pix_t p, input int unsigned ch);
    return p[8*ch +: 8];
  endfunction

endpackage

FILE: design/smrf_ram.sv
`timescale 1ns / 1ps

module smrf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/smrf_ctrl.sv
`timescale 1ns / 1ps

module smrf_ctrl import smrf_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [12:0]   cfg_data_i,
  input  logic          in_valid_i,
  input  logic [0:0]    opcode_i,
  input  pix_t          px_i,
  output logic          rd_en_o,
  output logic [CW-1:0] rd_addr_o,
  output item_t         s1_o,
  output logic [CW-1:0] s1_addr_o,
  output pix_t          capt_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [11:0] img_w_q;
  logic [12:0] img_h_q;
  logic [12:0] reg_rows_q;
  logic [11:0] reg_cols_q;

  logic [WW-1:0] eff_w, w_m1, cc_lim;
  logic [RW-1:0] eff_h, h_m1, rr_lim;

  logic [RW-1:0] in_row_q, out_row_q;
  logic [CW-1:0] in_col_q, out_col_q;

  item_t         s1_q;
  logic [CW-1:0] s1_addr_q;
  pix_t          capt_q;

  logic is_flush, pix_ok, fl_ok, take, emit, last, in_wrap, out_wrap;
  logic [CW-1:0] rd_addr;

  always_comb begin
    if (img_w_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      eff_h = RW'(1);
    end else if (32'(img_h_q) > 32'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(img_h_q);
    end
    w_m1 = eff_w - WW'(1);
    h_m1 = eff_h - RW'(1);
    if (32'(reg_rows_q) > 32'(eff_h)) begin
      rr_lim = eff_h;
    end else begin
      rr_lim = RW'(reg_rows_q);
    end
    if (32'(reg_cols_q) > 32'(eff_w)) begin
      cc_lim = eff_w;
    end else begin
      cc_lim = WW'(reg_cols_q);
    end
  end

  always_comb begin
    is_flush = (op_e'(opcode_i) == OP_FLUSH);
    pix_ok = !is_flush && (in_row_q < eff_h);
    fl_ok = is_flush && (in_row_q >= eff_h) && (out_row_q < eff_h);
    take = in_valid_i && en_i && (pix_ok || fl_ok);
    emit = fl_ok || (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
    in_wrap = (WW'(in_col_q) == w_m1);
    out_wrap = (WW'(out_col_q) == w_m1);
    last = (out_row_q == h_m1) && out_wrap;
    if (pix_ok) begin
      rd_addr = in_col_q;
    end else if (out_wrap) begin
      rd_addr = '0;
    end else begin
      rd_addr = out_col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= 12'd640;
      img_h_q    <= 13'd480;
      reg_rows_q <= 13'd480;
      reg_cols_q <= 12'd640;
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        CFG_REGION_ROWS:  reg_rows_q <= cfg_data_i;
        CFG_REGION_COLS:  reg_cols_q <= cfg_data_i[11:0];
        default: ;
      endcase
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (take) begin
      if (pix_ok) begin
        if (in_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (emit) begin
        if (last) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end else if (out_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s1_addr_q <= '0;
    end else if (en_i) begin
      s1_q.valid    <= take;
      s1_q.write    <= pix_ok;
      s1_q.emit     <= emit;
      s1_q.last     <= last;
      s1_q.top_c    <= (out_row_q == '0);
      s1_q.bot_c    <= (out_row_q >= h_m1);
      s1_q.left_c   <= (out_col_q == '0);
      s1_q.right_c  <= out_wrap;
      s1_q.region   <= (out_row_q < rr_lim) && (WW'(out_col_q) < cc_lim);
      s1_q.use_capt <= fl_ok && (eff_h == RW'(1)) && (out_col_q == '0);
      s1_q.px       <= px_i;
      s1_addr_q     <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pix_ok && (in_row_q == '0) && (in_col_q == '0)) begin
      capt_q <= px_i;
    end
  end

  assign rd_en_o   = take;
  assign rd_addr_o = rd_addr;
  assign s1_o      = s1_q;
  assign s1_addr_o = s1_addr_q;
  assign capt_o    = capt_q;

endmodule

FILE: design/smrf_window.sv
`timescale 1ns / 1ps

module smrf_window import smrf_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  item_t         s1_i,
  input  logic [CW-1:0] addr_i,
  input  logic [47:0]   rdata_i,
  input  pix_t          capt_i,
  output logic          we_o,
  output logic [CW-1:0] waddr_o,
  output logic [47:0]   wdata_o,
  output win_t          win_o
);

  logic          fwd_v_q;
  logic [CW-1:0] fwd_a_q;
  logic [47:0]   fwd_d_q;
  col_t          p1_q, p2_q;
  win_t          win_q;

  logic [47:0] rd;
  col_t        v_col, ceff, l_col, r_col;
  logic        we;

  always_comb begin
    rd = (fwd_v_q && (fwd_a_q == addr_i)) ? fwd_d_q : rdata_i;
    v_col.top = rd[47:24];
    v_col.mid = rd[23:0];
    v_col.bot = s1_i.px;
    if (s1_i.use_capt) begin
      ceff.top = capt_i;
      ceff.mid = capt_i;
      ceff.bot = capt_i;
    end else begin
      ceff = p1_q;
    end
    l_col = s1_i.left_c ? ceff : p2_q;
    r_col = s1_i.right_c ? ceff : v_col;
    we = en_i && s1_i.valid && s1_i.write;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
      fwd_a_q <= '0;
      fwd_d_q <= '0;
      win_q   <= '0;
    end else if (en_i) begin
      fwd_v_q       <= we;
      fwd_a_q       <= addr_i;
      fwd_d_q       <= {rd[23:0], s1_i.px};
      win_q.valid   <= s1_i.valid && s1_i.emit;
      win_q.replace <= (ceff.mid == WHITE) && s1_i.region;
      win_q.last    <= s1_i.last;
      win_q.l       <= clamp_col(l_col, s1_i.top_c, s1_i.bot_c);
      win_q.c       <= clamp_col(ceff, s1_i.top_c, s1_i.bot_c);
      win_q.r       <= clamp_col(r_col, s1_i.top_c, s1_i.bot_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_i.valid) begin
      p2_q <= ceff;
      p1_q <= v_col;
    end
  end

  assign we_o    = we;
  assign waddr_o = addr_i;
  assign wdata_o = {rd[23:0], s1_i.px};
  assign win_o   = win_q;

endmodule

FILE: design/smrf_median.sv
`timescale 1ns / 1ps

module smrf_median import smrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  win_t       win_i,
  output logic       out_valid_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic       replaced_o,
  output logic       frame_last_o
);

  tri_t       s3_q [3][3];
  logic       s3_valid_q, s3_rep_q, s3_last_q;
  pix_t       s3_ctr_q;

  logic [7:0] a_q [3];
  logic [7:0] b_q [3];
  logic [7:0] c_q [3];
  logic       s4_valid_q, s4_rep_q, s4_last_q;
  pix_t       s4_ctr_q;

  logic       out_valid_q, rep_q, last_q;
  pix_t       pix_q;
  pix_t       med;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      med[8*ch +: 8] = med3(a_q[ch], b_q[ch], c_q[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q  <= win_i.valid;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        s3_q[ch][0] <= sort3(chan(win_i.l.top, ch), chan(win_i.l.mid, ch),
                             chan(win_i.l.bot, ch));
        s3_q[ch][1] <= sort3(chan(win_i.c.top, ch), chan(win_i.c.mid, ch),
                             chan(win_i.c.bot, ch));
        s3_q[ch][2] <= sort3(chan(win_i.r.top, ch), chan(win_i.r.mid, ch),
                             chan(win_i.r.bot, ch));
        a_q[ch] <= max2(max2(s3_q[ch][0].lo, s3_q[ch][1].lo), s3_q[ch][2].lo);
        b_q[ch] <= med3(s3_q[ch][0].md, s3_q[ch][1].md, s3_q[ch][2].md);
        c_q[ch] <= min2(min2(s3_q[ch][0].hi, s3_q[ch][1].hi), s3_q[ch][2].hi);
      end
      s3_rep_q  <= win_i.replace;
      s3_last_q <= win_i.last;
      s3_ctr_q  <= win_i.c.mid;
      s4_rep_q  <= s3_rep_q;
      s4_last_q <= s3_last_q;
      s4_ctr_q  <= s3_ctr_q;
      rep_q     <= s4_rep_q;
      last_q    <= s4_last_q;
      pix_q     <= s4_rep_q ? med : s4_ctr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = pix_q[23:16];
  assign out_green_o  = pix_q[15:8];
  assign out_blue_o   = pix_q[7:0];
  assign replaced_o   = rep_q;
  assign frame_last_o = last_q;

endmodule

FILE: design/selective_median3x3_rgb_filter_core.sv
`timescale 1ns / 1ps
// Switching 3x3 median filter for an RGB pixel stream in raster order.
// Input channel: in_valid_i/in_stall_o with opcode_i (pixel or flush) and the
// three color channels. Output channel: out_valid_o/out_stall_i with the output
// pixel, a replaced flag and frame_last on the final pixel of the frame.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index and
// data; ready is always high and every write restarts the frame counters.
// One item is accepted per clock while the pipeline is not held. A pixel
// produces its result once the row below it has started, and flush items after
// the last pixel push out the remaining row plus one pixel. An item moves through
// the s1 and window registers and then the median stages to the output register.
// Two image rows live in one line memory of 48-bit entries, read once per item
// and written back per pixel item; the write of one item is forwarded to the
// next item when both touch the same column. The median network is three
// register stages. When the receiver stalls a valid output, the whole pipeline
// holds and in_stall_o follows. Reset returns the registers to 640x480 with a
// full-image region and clears the counters; the line memory is not cleared.
module selective_median3x3_rgb_filter_core import smrf_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  opcode_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        replaced_o,
  output logic        frame_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          en;
  logic          rd_en, ram_we;
  logic [CW-1:0] rd_addr, s1_addr, waddr;
  logic [47:0]   rdata, wdata;
  item_t         s1;
  pix_t          capt;
  win_t          win;

  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  smrf_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .px_i        ({in_red_i, in_green_i, in_blue_i}),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_o        (s1),
    .s1_addr_o   (s1_addr),
    .capt_o      (capt)
  );

  smrf_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  smrf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .s1_i    (s1),
    .addr_i  (s1_addr),
    .rdata_i (rdata),
    .capt_i  (capt),
    .we_o    (ram_we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .win_o   (win)
  );

  smrf_median u_median (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .win_i        (win),
    .out_valid_o  (out_valid_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .replaced_o   (replaced_o),
    .frame_last_o (frame_last_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output register");

  a_write_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!in_stall_o && s1.valid && s1.write))
    else $error("line memory written while the pipeline holds");

  a_replace_needs_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win.valid && win.replace) |-> (win.c.mid == WHITE))
    else $error("replacement flagged on a pixel that is not white");

  a_read_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (in_valid_i && !in_stall_o))
    else $error("line memory read without an accepted item");
`endif

endmodule
